>>> design/strr_pkg.sv
package strr_pkg;

    // Ring geometry
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = 6;
    localparam int TAG_W  = 48;
    localparam int OP_W   = 2;

    // Last slot of the ring, used for wrap-around
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    // Tag value of an invalid slot, also the "latest" lookup query
    localparam logic signed [TAG_W-1:0] TAG_INVALID = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

    // Slot after the given one, wrapping at the end of the ring
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    // Slot before the given one, wrapping at the start of the ring
    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        slot_dec = (s == '0) ? SLOT_LAST : s - 1'b1;
    endfunction

endpackage

>>> design/strr_ram.sv
module strr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/sequence_tagged_result_ring_core.sv
// Sequence-tagged result ring.
// Input channel (s_valid/s_ready): s_operation selects acquire, commit or lookup;
// s_sequence_req carries the frame sequence for commit and lookup, -1 on lookup
// asks for the newest slot. Operation code 3 is taken and dropped, no item out.
// Result channel (m_valid/m_ready): one item per operation with the slot index,
// a found flag and the slot's tag (-1 when invalid or when nothing was found).
// Tags live in a 16-entry RAM with a registered read port; a valid bit per entry makes
// an entry never written since reset read as invalid, so no clearing pass runs.
// Sequence, one item at a time:
//   acquire and commit write the RAM on acceptance and go to the result state;
//   from there the result moves to the output register and the block returns to idle.
//   latest lookup: one RAM read, then the result state.
//   search lookup: one RAM entry per cycle from newest to oldest over the RAM
//   read port, up to SLOTS entries, then the result state.
// A result waits in the output register while the receiver stalls; the block
// then holds the next result and takes no new item until the register frees.
// Reset (aresetn low, synchronous) empties the ring: no newest slot, all tags
// invalid, output register empty.
module sequence_tagged_result_ring_core
    import strr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic signed [TAG_W-1:0] s_sequence_req,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_slot_index,
    output logic                    m_found,
    output logic signed [TAG_W-1:0] m_slot_tag
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LATEST = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic                    newest_vld_reg, newest_vld_next;
    logic [SLOT_W-1:0]       newest_reg, newest_next;
    logic [SLOTS-1:0]        tag_vld_reg;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [SLOT_W-1:0]       cnt_reg, cnt_next;
    logic signed [TAG_W-1:0] seq_reg, seq_next;

    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic                    res_found_reg, res_found_next;
    logic signed [TAG_W-1:0] res_tag_reg, res_tag_next;

    logic                    m_valid_reg;
    logic [IDX_W-1:0]        m_slot_reg;
    logic                    m_found_reg;
    logic signed [TAG_W-1:0] m_tag_reg;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [TAG_W-1:0]        ram_wdata;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [TAG_W-1:0]        ram_rdata;

    logic                    in_fire;
    logic                    out_free;
    logic [SLOT_W-1:0]       next_slot;
    logic [SLOT_W-1:0]       newest_or_zero;
    logic signed [TAG_W-1:0] tag_eff;
    logic                    tag_hit;

    strr_ram #(
        .WIDTH(TAG_W),
        .DEPTH(SLOTS)
    ) u_tag_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign next_slot      = newest_vld_reg ? slot_inc(newest_reg) : '0;
    assign newest_or_zero = newest_vld_reg ? newest_reg : '0;

    // Tag of the slot read last cycle; never-written entries read invalid
    assign tag_eff = tag_vld_reg[cur_reg] ? $signed(ram_rdata) : TAG_INVALID;
    assign tag_hit = !tag_eff[TAG_W-1] && (seq_reg >= tag_eff);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        newest_vld_next = newest_vld_reg;
        newest_next     = newest_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        seq_next        = seq_reg;
        res_slot_next   = res_slot_reg;
        res_found_next  = res_found_reg;
        res_tag_next    = res_tag_reg;
        ram_we          = 1'b0;
        ram_waddr       = next_slot;
        ram_wdata       = TAG_INVALID;
        ram_raddr       = cur_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_operation)
                        OP_ACQUIRE: begin
                            ram_we         = 1'b1;
                            res_slot_next  = next_slot;
                            res_found_next = 1'b1;
                            res_tag_next   = TAG_INVALID;
                            state_next     = ST_RESULT;
                        end
                        OP_COMMIT: begin
                            ram_we          = 1'b1;
                            ram_wdata       = s_sequence_req;
                            newest_next     = next_slot;
                            newest_vld_next = 1'b1;
                            res_slot_next   = next_slot;
                            res_found_next  = 1'b1;
                            res_tag_next    = s_sequence_req;
                            state_next      = ST_RESULT;
                        end
                        OP_LOOKUP: begin
                            seq_next = s_sequence_req;
                            cnt_next = '0;
                            if (s_sequence_req == TAG_INVALID) begin
                                cur_next   = newest_or_zero;
                                state_next = ST_LATEST;
                            end else begin
                                cur_next   = newest_vld_reg ? newest_reg : SLOT_LAST;
                                state_next = ST_SEARCH;
                            end
                            ram_raddr = cur_next;
                        end
                        default: begin
                            // unknown code: item dropped, state untouched
                        end
                    endcase
                end
            end
            ST_LATEST: begin
                res_slot_next  = cur_reg;
                res_found_next = 1'b1;
                res_tag_next   = tag_eff;
                state_next     = ST_RESULT;
            end
            ST_SEARCH: begin
                // one entry per cycle, newest to oldest
                if (tag_hit) begin
                    res_slot_next  = cur_reg;
                    res_found_next = 1'b1;
                    res_tag_next   = tag_eff;
                    state_next     = ST_RESULT;
                end else if (cnt_reg == SLOT_LAST) begin
                    res_slot_next  = '0;
                    res_found_next = 1'b0;
                    res_tag_next   = TAG_INVALID;
                    state_next     = ST_RESULT;
                end else begin
                    cur_next  = slot_dec(cur_reg);
                    ram_raddr = cur_next;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            newest_vld_reg <= 1'b0;
            newest_reg     <= '0;
            tag_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            newest_vld_reg <= newest_vld_next;
            newest_reg     <= newest_next;
            if (ram_we) begin
                tag_vld_reg[ram_waddr] <= 1'b1;
            end
            if (state_reg == ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        seq_reg       <= seq_next;
        res_slot_reg  <= res_slot_next;
        res_found_reg <= res_found_next;
        res_tag_reg   <= res_tag_next;
        if (state_reg == ST_RESULT && out_free) begin
            m_slot_reg  <= IDX_W'(res_slot_reg);
            m_found_reg <= res_found_reg;
            m_tag_reg   <= res_tag_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_slot_reg;
    assign m_found      = m_found_reg;
    assign m_slot_tag   = m_tag_reg;

    // A miss always reports slot 0 with an invalid tag
    a_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_slot_index == '0) && (m_slot_tag == TAG_INVALID))
        else $error("miss result carries slot or tag");

    // Acquire and commit go straight to the result stage
    a_write_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_operation == OP_ACQUIRE || s_operation == OP_COMMIT)
        |=> state_reg == ST_RESULT)
        else $error("write operation did not reach result stage");

    // Walk never runs past the ring
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH && !tag_hit && cnt_reg == SLOT_LAST
        |=> state_reg == ST_RESULT && !res_found_reg)
        else $error("search walked past the last slot");

    // A found search result is a valid tag not above the query
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH && tag_hit
        |=> res_found_reg && !res_tag_reg[TAG_W-1] && (seq_reg >= res_tag_reg))
        else $error("search hit with bad tag");

    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

>>> tb/sv/sequence_tagged_result_ring_checker.sv
// Watches both channels of the result ring, keeps its own copy of the ring
// and compares every result item against the oldest predicted one.
module sequence_tagged_result_ring_checker
    import strr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic signed [TAG_W-1:0] s_sequence_req,

    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [IDX_W-1:0]        m_slot_index,
    input  logic                    m_found,
    input  logic signed [TAG_W-1:0] m_slot_tag,

    output int                      error_count,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IDX_W-1:0]        slot_index;
        logic                    found;
        logic signed [TAG_W-1:0] slot_tag;
    } slot_result_t;

    // Shadow ring: newest pointer plus one tag per slot
    bit                      have_newest;
    int                      newest_idx;
    logic signed [TAG_W-1:0] ring_tags [SLOTS];

    slot_result_t            expected_results [$];
    int                      misses;

    initial begin
        error_count = 0;
        outstanding = 0;
        misses      = 0;
    end

    function automatic void clear_ring();
        have_newest = 1'b0;
        newest_idx  = 0;
        for (int i = 0; i < SLOTS; i++) begin
            ring_tags[i] = TAG_INVALID;
        end
    endfunction

    // Slot that acquire and commit work on
    function automatic int slot_after_newest();
        return have_newest ? (newest_idx + 1) % SLOTS : 0;
    endfunction

    // Updates the shadow ring for one item; returns 0 when no result follows
    function automatic bit ring_update(input logic [OP_W-1:0] op,
                                       input logic signed [TAG_W-1:0] seq,
                                       output slot_result_t res);
        int  idx;
        int  walk_start;
        bit  hit;
        res = '{slot_index: '0, found: 1'b1, slot_tag: TAG_INVALID};
        case (op)
            OP_ACQUIRE: begin
                idx = slot_after_newest();
                ring_tags[idx] = TAG_INVALID;
                res.slot_index = IDX_W'(idx);
            end
            OP_COMMIT: begin
                idx = slot_after_newest();
                have_newest    = 1'b1;
                newest_idx     = idx;
                ring_tags[idx] = seq;
                res.slot_index = IDX_W'(idx);
                res.slot_tag   = seq;
            end
            OP_LOOKUP: begin
                if (seq == TAG_INVALID) begin
                    // latest: newest slot, or slot 0 on an empty ring
                    idx = have_newest ? newest_idx : 0;
                    res.slot_index = IDX_W'(idx);
                    res.slot_tag   = ring_tags[idx];
                end else begin
                    // newest-to-oldest walk for a valid tag not above the query
                    walk_start = have_newest ? newest_idx : SLOTS - 1;
                    hit        = 1'b0;
                    res.found  = 1'b0;
                    for (int i = 0; i < SLOTS; i++) begin
                        idx = (walk_start + SLOTS - i) % SLOTS;
                        if (!hit && !ring_tags[idx][TAG_W-1] && seq >= ring_tags[idx]) begin
                            hit            = 1'b1;
                            res.found      = 1'b1;
                            res.slot_index = IDX_W'(idx);
                            res.slot_tag   = ring_tags[idx];
                        end
                    end
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void note_miss(input string what,
                                      input logic signed [63:0] want,
                                      input logic signed [63:0] got);
        misses++;
        if (misses <= MAX_REPORTS) begin
            $display("%0t: result ring %s mismatch: expected %0d, got %0d",
                     $realtime, what, want, got);
        end
    endfunction

    // Compare first, then predict: no item can leave in the cycle it enters
    always @(posedge aclk) begin : watch
        slot_result_t got;
        slot_result_t want;
        slot_result_t fresh;
        if (!aresetn) begin
            clear_ring();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{slot_index: m_slot_index, found: m_found, slot_tag: m_slot_tag};
                if (expected_results.size() == 0) begin
                    misses++;
                    if (misses <= MAX_REPORTS) begin
                        $display("%0t: result ring item with none pending: slot %0d found %0b tag %0d",
                                 $realtime, got.slot_index, got.found, $signed(got.slot_tag));
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.slot_index != want.slot_index) begin
                        note_miss("slot_index", want.slot_index, got.slot_index);
                    end
                    if (got.found != want.found) begin
                        note_miss("found", want.found, got.found);
                    end
                    if (got.slot_tag != want.slot_tag) begin
                        note_miss("slot_tag", $signed(want.slot_tag), $signed(got.slot_tag));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (ring_update(s_operation, s_sequence_req, fresh)) begin
                    expected_results.push_back(fresh);
                end
            end
        end
        error_count <= misses;
        outstanding <= expected_results.size();
    end

endmodule

>>> tb/sv/sequence_tagged_result_ring_core_tb.sv
// Drives operations into the result ring, stalls the result side and
// reports the verdict from the checker's counts.
module sequence_tagged_result_ring_core_tb;
    import strr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0]         OP_UNUSED   = 2'd3;
    localparam logic signed [TAG_W-1:0] SEQ_MAX     = {1'b0, {(TAG_W-1){1'b1}}};
    localparam logic signed [TAG_W-1:0] SEQ_MIN     = {1'b1, {(TAG_W-1){1'b0}}};
    localparam int                      RANDOM_OPS  = 930;
    localparam int                      HOLD_CYCLES = 200;
    localparam int                      DRAIN_LIMIT = 20000;
    localparam int                      TIMEOUT_NS  = 2_000_000;

    typedef enum int {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_SPARSE} rx_mode_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation    = OP_ACQUIRE;
    logic signed [TAG_W-1:0] s_sequence_req = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [IDX_W-1:0]        m_slot_index;
    logic                    m_found;
    logic signed [TAG_W-1:0] m_slot_tag;

    int                      error_count;
    int                      outstanding;
    int                      burst_left = 0;

    sequence_tagged_result_ring_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_sequence_req (s_sequence_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_index   (m_slot_index),
        .m_found        (m_found),
        .m_slot_tag     (m_slot_tag)
    );

    sequence_tagged_result_ring_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_sequence_req (s_sequence_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_index   (m_slot_index),
        .m_found        (m_found),
        .m_slot_tag     (m_slot_tag),
        .error_count    (error_count),
        .outstanding    (outstanding)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[sequence_tagged_result_ring_core] ERROR");
        $finish;
    end

    function automatic logic signed [TAG_W-1:0] any_seq();
        return TAG_W'({$urandom(), $urandom()});
    endfunction

    // Offer one item and hold it until taken; bursts end in a random gap
    task automatic send_op(input logic [OP_W-1:0] op, input logic signed [TAG_W-1:0] seq);
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_sequence_req <= seq;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Result side: random stall patterns, with two long hold-offs early on
    initial begin : receiver
        int       seg_no;
        int       seg_len;
        rx_mode_t mode;
        seg_no = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (seg_no == 3 || seg_no == 11) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                seg_len = $urandom_range(20, 120);
                repeat (seg_len) begin
                    case (mode)
                        RX_OPEN:       m_ready <= 1'b1;
                        RX_COIN:       m_ready <= ($urandom_range(0, 1) == 1);
                        RX_RARE_STALL: m_ready <= ($urandom_range(0, 7) != 0);
                        default:       m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
            seg_no++;
        end
    end

    initial begin : stimulus
        logic signed [TAG_W-1:0] frame_seq;
        int                      rand_ops;
        int                      pick;
        int                      drain_cycles;
        frame_seq = TAG_W'($urandom_range(0, 1000));
        rand_ops  = 0;
        while (!aresetn) @(posedge aclk);

        // Empty ring: latest gives slot 0, a search finds nothing
        send_op(OP_LOOKUP, TAG_INVALID);
        send_op(OP_LOOKUP, 48'sd100);
        send_op(OP_ACQUIRE, '0);
        send_op(OP_LOOKUP, TAG_INVALID);
        // Field extremes, negative tags stored but never matched
        send_op(OP_COMMIT, '0);
        send_op(OP_LOOKUP, '0);
        send_op(OP_LOOKUP, -48'sd2);
        send_op(OP_COMMIT, SEQ_MAX);
        send_op(OP_COMMIT, -48'sd5);
        send_op(OP_COMMIT, SEQ_MIN);
        send_op(OP_LOOKUP, SEQ_MAX);
        send_op(OP_LOOKUP, SEQ_MAX - 1);
        send_op(OP_LOOKUP, SEQ_MIN);
        send_op(OP_LOOKUP, TAG_INVALID);
        // Unused code is dropped without a result
        send_op(OP_UNUSED, '0);
        send_op(OP_UNUSED, '1);
        // Repeated acquire reuses the same slot
        send_op(OP_ACQUIRE, SEQ_MAX);
        send_op(OP_ACQUIRE, SEQ_MIN);
        send_op(OP_LOOKUP, TAG_INVALID);
        send_op(OP_COMMIT, 48'sd7);
        send_op(OP_LOOKUP, 48'sd6);

        // Mostly acquire/commit frames with lookups around recent sequences
        while (rand_ops < RANDOM_OPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_op(OP_ACQUIRE, any_seq());
            end else if (pick < 58) begin
                frame_seq = frame_seq + TAG_W'($urandom_range(1, 3));
                send_op(OP_COMMIT, frame_seq);
            end else if (pick < 90) begin
                case ($urandom_range(0, 5))
                    0:       send_op(OP_LOOKUP, TAG_INVALID);
                    1, 2:    send_op(OP_LOOKUP, frame_seq - TAG_W'($urandom_range(0, 48)));
                    3:       send_op(OP_LOOKUP, any_seq());
                    4:       send_op(OP_LOOKUP, frame_seq + TAG_W'($urandom_range(0, 5)));
                    default: send_op(OP_LOOKUP, $urandom_range(0, 1) ? SEQ_MAX : '0);
                endcase
            end else if (pick < 93) begin
                send_op(OP_COMMIT, any_seq());
            end else if (pick < 97) begin
                // jump the frame counter anywhere in the positive range
                frame_seq = $urandom_range(0, 1) ? (any_seq() & SEQ_MAX)
                                                 : TAG_W'($urandom_range(0, 200));
                send_op(OP_COMMIT, frame_seq);
            end else begin
                send_op(OP_UNUSED, any_seq());
                rand_ops--;
            end
            rand_ops++;
        end
        s_valid <= 1'b0;

        // Let the last prediction land, then drain
        @(posedge aclk);
        drain_cycles = 0;
        while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (2 * SLOTS) @(posedge aclk);

        if (error_count == 0 && outstanding == 0) begin
            $display("[sequence_tagged_result_ring_core] OK");
        end else begin
            $display("[sequence_tagged_result_ring_core] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
design/strr_pkg.sv
design/strr_ram.sv
design/sequence_tagged_result_ring_core.sv
tb/sv/sequence_tagged_result_ring_checker.sv
tb/sv/sequence_tagged_result_ring_core_tb.sv
